@@ rtl/core/chlg_pkg.sv @@
// Shared types, constants and codes of the core-count governor.
package chlg_pkg;

  localparam int WINDOW    = 10;
  localparam int MAX_CORES = 8;

  localparam int LOAD_W     = 17;
  localparam int RUN_W      = 10;
  localparam int CORE_W     = 4;
  localparam int THR_W      = 10;
  localparam int DELAY_W    = 7;
  localparam int LOAD_SCALE = 100;
  localparam int DELAY_MAX  = 127;

  localparam int CNT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = LOAD_W + $clog2(WINDOW);
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam int FLAG_DISABLED = 0;
  localparam int FLAG_PAUSED   = 1;
  localparam int FLAG_BOOST    = 2;
  localparam int FLAG_SUSPEND  = 3;

  typedef enum logic [2:0] {
    OP_SAMPLE       = 3'd0,
    OP_BOOST        = 3'd1,
    OP_SET_DISABLE  = 3'd2,
    OP_UNPAUSE      = 3'd3,
    OP_SUSPEND      = 3'd4,
    OP_RESUME       = 3'd5,
    OP_OFFLINE_DONE = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ONLINE_ALL  = 3'd1,
    ACT_ONLINE_ONE  = 3'd2,
    ACT_OFFLINE_ONE = 3'd3,
    ACT_OFFLINE_ALL = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    CFG_AVAILABLE = 3'd0,
    CFG_MIN       = 3'd1,
    CFG_MAX       = 3'd2,
    CFG_ENABLE    = 3'd3,
    CFG_DISABLE   = 3'd4,
    CFG_ALL       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_ROTATE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CORE_W-1:0] avail;
    logic [CORE_W-1:0] min_cores;
    logic [CORE_W-1:0] max_cores;
    logic [THR_W-1:0]  enable_per_core;
    logic [THR_W-1:0]  disable_per_core;
    logic [THR_W-1:0]  all_per_core;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic insert;
  } ring_ctrl_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [CORE_W-1:0] online;
    logic              req;
    logic [LOAD_W-1:0] avg;
    logic [3:0]        flags;
    logic              pending;
  } pol_in_t;

  typedef struct packed {
    logic [2:0]         action;
    logic               sched;
    logic [DELAY_W-1:0] delay;
    logic               unpause;
    logic               cancel;
    logic [3:0]         flags;
    logic               pending;
    logic [LOAD_W-1:0]  avg;
  } pol_out_t;

endpackage

@@ rtl/core/cpu_hotplug_load_governor.sv @@
// Top level of the event-driven core-count governor.
//
// Each accepted input beat is one governor event and yields exactly one
// result beat. A sample event stores run_count*100 in a ring of WINDOW cells
// and then walks the ring once, one cell a cycle, to sum it; the sum is
// divided by WINDOW with a reciprocal multiply and the policy then picks
// the action. A sample event therefore occupies the block from acceptance
// through the insert, the ring walk and the divide until the next beat can
// be accepted; every other event goes straight to the finish step. One
// event is in progress at a time; the result sits in an output register, so
// the next beat is taken while that result still waits for the consumer,
// and the block only holds back when a second result is ready before the
// first has been taken. The ring is cleared by reset, and configuration
// registers are written through a separate port that is always ready; they
// should only be written while no event is in progress.

module cpu_hotplug_load_governor (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [chlg_pkg::THR_W-1:0]    cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic [chlg_pkg::RUN_W-1:0]    run_count_i,
  input  logic [chlg_pkg::CORE_W-1:0]   online_now_i,
  input  logic                          disable_request_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    action_o,
  output logic                          decision_scheduled_o,
  output logic [chlg_pkg::DELAY_W-1:0]  decision_delay_o,
  output logic                          start_unpause_timer_o,
  output logic                          cancel_timers_o,
  output logic [4:0]                    status_flags_o,
  output logic [chlg_pkg::LOAD_W-1:0]   average_load_o
);

  chlg_pkg::cfg_t cfg_q;

  chlg_pkg::state_e state_q, state_d;
  logic [chlg_pkg::CNT_W-1:0] rot_cnt_q, rot_cnt_d;

  // Captured event beat.
  logic [2:0]                  op_q;
  logic [chlg_pkg::RUN_W-1:0]  run_q;
  logic [chlg_pkg::CORE_W-1:0] online_q;
  logic                        req_q;

  logic [3:0] flags_q;
  logic       pending_q;

  chlg_pkg::ring_ctrl_t        ring_ctrl;
  logic [chlg_pkg::LOAD_W-1:0] new_load;
  logic [chlg_pkg::SUM_W-1:0]  ring_sum;
  logic [chlg_pkg::PROD_W-1:0] prod_q;

  chlg_pkg::pol_in_t  pol_in;
  chlg_pkg::pol_out_t pol_out;

  logic in_accept;
  logic out_free;
  logic finish;

  chlg_pkg::pol_out_t res_q;
  logic               out_valid_q;

  // Configuration: the port never stalls; unknown indices are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avail            <= chlg_pkg::CORE_W'(4);
      cfg_q.min_cores        <= chlg_pkg::CORE_W'(1);
      cfg_q.max_cores        <= chlg_pkg::CORE_W'(4);
      cfg_q.enable_per_core  <= chlg_pkg::THR_W'(300);
      cfg_q.disable_per_core <= chlg_pkg::THR_W'(60);
      cfg_q.all_per_core     <= chlg_pkg::THR_W'(100);
    end else if (cfg_valid_i) begin
      unique case (chlg_pkg::cfg_idx_e'(cfg_index_i))
        chlg_pkg::CFG_AVAILABLE: cfg_q.avail            <= cfg_data_i[chlg_pkg::CORE_W-1:0];
        chlg_pkg::CFG_MIN:       cfg_q.min_cores        <= cfg_data_i[chlg_pkg::CORE_W-1:0];
        chlg_pkg::CFG_MAX:       cfg_q.max_cores        <= cfg_data_i[chlg_pkg::CORE_W-1:0];
        chlg_pkg::CFG_ENABLE:    cfg_q.enable_per_core  <= cfg_data_i;
        chlg_pkg::CFG_DISABLE:   cfg_q.disable_per_core <= cfg_data_i;
        chlg_pkg::CFG_ALL:       cfg_q.all_per_core     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != chlg_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: for a sample, insert, walk the ring and divide; every event then hands the result over.
  always_comb begin
    state_d   = state_q;
    rot_cnt_d = rot_cnt_q;
    ring_ctrl = '0;
    finish    = 1'b0;
    unique case (state_q)
      chlg_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (chlg_pkg::op_e'(operation_i) == chlg_pkg::OP_SAMPLE)
                  ? chlg_pkg::ST_INSERT : chlg_pkg::ST_FINISH;
        end
      end
      chlg_pkg::ST_INSERT: begin
        ring_ctrl.shift  = 1'b1;
        ring_ctrl.insert = 1'b1;
        rot_cnt_d        = '0;
        state_d          = chlg_pkg::ST_ROTATE;
      end
      chlg_pkg::ST_ROTATE: begin
        // A full turn of the ring restores the oldest-at-tail order.
        ring_ctrl.shift = 1'b1;
        if (rot_cnt_q == chlg_pkg::CNT_W'(chlg_pkg::WINDOW - 1)) begin
          state_d = chlg_pkg::ST_DIVIDE;
        end else begin
          rot_cnt_d = rot_cnt_q + chlg_pkg::CNT_W'(1);
        end
      end
      chlg_pkg::ST_DIVIDE: begin
        state_d = chlg_pkg::ST_FINISH;
      end
      chlg_pkg::ST_FINISH: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = chlg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chlg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= chlg_pkg::ST_IDLE;
      rot_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      rot_cnt_q <= rot_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= operation_i;
      run_q    <= run_count_i;
      online_q <= online_now_i;
      req_q    <= disable_request_i;
    end
  end

  assign new_load = chlg_pkg::LOAD_W'(run_q) * chlg_pkg::LOAD_W'(chlg_pkg::LOAD_SCALE);

  chlg_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ring_ctrl),
    .new_load_i (new_load),
    .sum_o      (ring_sum)
  );

  // Division by the window length as a multiply by its rounded-up reciprocal,
  // exact over the whole range of the sum.
  always_ff @(posedge clk_i) begin
    if (state_q == chlg_pkg::ST_DIVIDE) begin
      prod_q <= chlg_pkg::PROD_W'(ring_sum) * chlg_pkg::PROD_W'(chlg_pkg::RECIP);
    end
  end

  assign pol_in.op      = op_q;
  assign pol_in.online  = online_q;
  assign pol_in.req     = req_q;
  assign pol_in.avg     = prod_q[chlg_pkg::DIV_SHIFT +: chlg_pkg::LOAD_W];
  assign pol_in.flags   = flags_q;
  assign pol_in.pending = pending_q;

  chlg_policy u_policy (
    .cfg_i (cfg_q),
    .pol_i (pol_in),
    .pol_o (pol_out)
  );

  // Mode flags start with the governor paused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= 4'b0010;
      pending_q <= 1'b0;
    end else if (finish) begin
      flags_q   <= pol_out.flags;
      pending_q <= pol_out.pending;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= pol_out;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign action_o              = res_q.action;
  assign decision_scheduled_o  = res_q.sched;
  assign decision_delay_o      = res_q.delay;
  assign start_unpause_timer_o = res_q.unpause;
  assign cancel_timers_o       = res_q.cancel;
  assign status_flags_o        = {res_q.pending, res_q.flags};
  assign average_load_o        = res_q.avg;

endmodule

@@ rtl/core/chlg_cell.sv @@
// One cell of the load ring: holds a single scaled load sample.
module chlg_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [chlg_pkg::LOAD_W-1:0]  load_i,
  output logic [chlg_pkg::LOAD_W-1:0]  load_o
);

  logic [chlg_pkg::LOAD_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (shift_i) begin
      value_q <= load_i;
    end
  end

  assign load_o = value_q;

endmodule

@@ rtl/core/chlg_ring.sv @@
// Ring of load cells with the accumulator fed from the tail cell.
module chlg_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chlg_pkg::ring_ctrl_t         ctrl_i,
  input  logic [chlg_pkg::LOAD_W-1:0]  new_load_i,
  output logic [chlg_pkg::SUM_W-1:0]   sum_o
);

  logic [chlg_pkg::LOAD_W-1:0] cell_in  [chlg_pkg::WINDOW];
  logic [chlg_pkg::LOAD_W-1:0] cell_out [chlg_pkg::WINDOW];
  logic [chlg_pkg::SUM_W-1:0]  sum_q;
  logic [chlg_pkg::SUM_W-1:0]  sum_d;

  // The head takes the new sample on insert, otherwise the tail wraps round.
  // Inserting drops the tail, which is always the oldest sample.
  assign cell_in[0] = ctrl_i.insert ? new_load_i : cell_out[chlg_pkg::WINDOW-1];

  for (genvar k = 0; k < chlg_pkg::WINDOW; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    chlg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.shift),
      .load_i  (cell_in[k]),
      .load_o  (cell_out[k])
    );
  end

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.shift) begin
      if (ctrl_i.insert) begin
        sum_d = '0;
      end else begin
        sum_d = sum_q + chlg_pkg::SUM_W'(cell_out[chlg_pkg::WINDOW-1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/core/chlg_policy.sv @@
// Decision logic: result fields and next mode flags for one event.
module chlg_policy (
  input  chlg_pkg::cfg_t     cfg_i,
  input  chlg_pkg::pol_in_t  pol_i,
  output chlg_pkg::pol_out_t pol_o
);

  logic [chlg_pkg::CORE_W-1:0]  avail;
  logic [chlg_pkg::CORE_W-1:0]  mn;
  logic [chlg_pkg::CORE_W-1:0]  mx;
  logic [2*chlg_pkg::CORE_W-1:0] sq;
  logic [chlg_pkg::DELAY_W-1:0] slow;
  logic [chlg_pkg::LOAD_W-1:0]  all_load;
  logic [chlg_pkg::LOAD_W-1:0]  en_load;
  logic [chlg_pkg::LOAD_W-1:0]  dis_load;
  logic                         room;

  // Out-of-range core settings fall back to safe values.
  always_comb begin
    if (cfg_i.avail == '0) begin
      avail = chlg_pkg::CORE_W'(1);
    end else if ((chlg_pkg::CORE_W+1)'(cfg_i.avail) >
                 (chlg_pkg::CORE_W+1)'(chlg_pkg::MAX_CORES)) begin
      avail = chlg_pkg::CORE_W'(chlg_pkg::MAX_CORES);
    end else begin
      avail = cfg_i.avail;
    end
    mn = (cfg_i.min_cores == '0 || cfg_i.min_cores > avail) ? chlg_pkg::CORE_W'(1)
                                                            : cfg_i.min_cores;
    mx = (cfg_i.max_cores == '0 || cfg_i.max_cores > avail) ? avail : cfg_i.max_cores;
  end

  assign sq   = (2*chlg_pkg::CORE_W)'(pol_i.online) * (2*chlg_pkg::CORE_W)'(pol_i.online);
  assign slow = (sq > (2*chlg_pkg::CORE_W)'(chlg_pkg::DELAY_MAX))
              ? chlg_pkg::DELAY_W'(chlg_pkg::DELAY_MAX) : chlg_pkg::DELAY_W'(sq);

  assign all_load = chlg_pkg::LOAD_W'(cfg_i.all_per_core) * chlg_pkg::LOAD_W'(avail);
  assign en_load  = chlg_pkg::LOAD_W'(cfg_i.enable_per_core) * chlg_pkg::LOAD_W'(pol_i.online);
  assign dis_load = chlg_pkg::LOAD_W'(cfg_i.disable_per_core) * chlg_pkg::LOAD_W'(pol_i.online);
  assign room     = (pol_i.online < avail) && (mx > pol_i.online);

  always_comb begin
    pol_o         = '0;
    pol_o.flags   = pol_i.flags;
    pol_o.pending = pol_i.pending;
    unique case (chlg_pkg::op_e'(pol_i.op))
      chlg_pkg::OP_SAMPLE: begin
        pol_o.avg   = pol_i.avg;
        pol_o.sched = 1'b1;
        pol_o.delay = slow;
        if (!pol_i.flags[chlg_pkg::FLAG_DISABLED]) begin
          priority if (pol_i.avg >= all_load && room) begin
            pol_o.flags[chlg_pkg::FLAG_PAUSED] = 1'b1;
            pol_o.pending = 1'b0;
            pol_o.action  = chlg_pkg::ACT_ONLINE_ALL;
            pol_o.delay   = chlg_pkg::DELAY_W'(1);
            pol_o.unpause = 1'b1;
          end else if (pol_i.flags[chlg_pkg::FLAG_PAUSED]) begin
            pol_o.delay = chlg_pkg::DELAY_W'(1);
          end else if (pol_i.avg >= en_load && room) begin
            pol_o.pending = 1'b0;
            pol_o.action  = chlg_pkg::ACT_ONLINE_ONE;
            pol_o.delay   = chlg_pkg::DELAY_W'(1);
          end else if (pol_i.avg <= dis_load && mn < pol_i.online) begin
            // A removal already in flight is not scheduled twice.
            if (!pol_i.pending) begin
              pol_o.pending = 1'b1;
              pol_o.action  = chlg_pkg::ACT_OFFLINE_ONE;
            end
            pol_o.flags[chlg_pkg::FLAG_BOOST] = 1'b0;
          end else begin
            pol_o.pending = pol_i.pending;
          end
        end
      end
      chlg_pkg::OP_BOOST: begin
        if (!pol_i.flags[chlg_pkg::FLAG_SUSPEND] && !pol_i.flags[chlg_pkg::FLAG_DISABLED] &&
            !pol_i.flags[chlg_pkg::FLAG_BOOST] && mx > pol_i.online) begin
          pol_o.flags[chlg_pkg::FLAG_BOOST] = 1'b1;
          if (pol_i.online < chlg_pkg::CORE_W'(2)) begin
            pol_o.pending = 1'b0;
            pol_o.flags[chlg_pkg::FLAG_PAUSED] = 1'b1;
            pol_o.action  = chlg_pkg::ACT_ONLINE_ONE;
            pol_o.sched   = 1'b1;
            pol_o.delay   = chlg_pkg::DELAY_W'(1);
            pol_o.unpause = 1'b1;
          end else if (pol_i.pending) begin
            pol_o.pending = 1'b0;
            pol_o.flags[chlg_pkg::FLAG_PAUSED] = 1'b1;
            pol_o.sched   = 1'b1;
            pol_o.delay   = chlg_pkg::DELAY_W'(1);
            pol_o.unpause = 1'b1;
          end
        end
      end
      chlg_pkg::OP_SET_DISABLE: begin
        if (pol_i.flags[chlg_pkg::FLAG_DISABLED] && !pol_i.req) begin
          pol_o.flags[chlg_pkg::FLAG_DISABLED] = 1'b0;
          pol_o.flags[chlg_pkg::FLAG_PAUSED]   = 1'b0;
          pol_o.sched = 1'b1;
        end else if (pol_i.req && !pol_i.flags[chlg_pkg::FLAG_DISABLED]) begin
          pol_o.flags[chlg_pkg::FLAG_DISABLED] = 1'b1;
          pol_o.pending = 1'b0;
          pol_o.cancel  = 1'b1;
        end
      end
      chlg_pkg::OP_UNPAUSE: begin
        pol_o.flags[chlg_pkg::FLAG_PAUSED] = 1'b0;
      end
      chlg_pkg::OP_SUSPEND: begin
        pol_o.flags[chlg_pkg::FLAG_SUSPEND] = 1'b1;
        pol_o.pending = 1'b0;
        pol_o.cancel  = 1'b1;
        if (pol_i.online > chlg_pkg::CORE_W'(1)) begin
          pol_o.action = chlg_pkg::ACT_OFFLINE_ALL;
        end
      end
      chlg_pkg::OP_RESUME: begin
        pol_o.flags[chlg_pkg::FLAG_SUSPEND] = 1'b0;
        pol_o.action  = chlg_pkg::ACT_ONLINE_ALL;
        pol_o.sched   = 1'b1;
        pol_o.delay   = chlg_pkg::DELAY_W'(1);
        pol_o.unpause = 1'b1;
      end
      chlg_pkg::OP_OFFLINE_DONE: begin
        pol_o.pending = 1'b0;
        pol_o.sched   = 1'b1;
        pol_o.delay   = chlg_pkg::DELAY_W'(1);
      end
      default: begin
        pol_o.flags   = pol_i.flags;
        pol_o.pending = pol_i.pending;
      end
    endcase
  end

endmodule
